### hw/rtl/battery_voltage_averager_core_macros.svh
// Assertion macros shared by the averager checker.
`ifndef BATTERY_VOLTAGE_AVERAGER_CORE_MACROS_SVH
`define BATTERY_VOLTAGE_AVERAGER_CORE_MACROS_SVH

// Property checked outside reset.
`define BVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked at every edge, reset included.
`define BVA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/bva_pkg.sv
// Types and constants shared by the battery voltage averager.
`default_nettype none
package bva_pkg;

  localparam int MV_W      = 14;
  localparam int ADC_W     = 12;
  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = ADC_W + MV_W;
  localparam int PCT_NUM_W = 21;  // 16383 * 100 fits

  localparam logic [MV_W-1:0]  MV_MAX   = '1;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;
  localparam logic [6:0]       PCT_MUL  = 7'd100;

  localparam logic [MV_W-1:0] RST_FULL_SCALE = 14'd9900;
  localparam logic [MV_W-1:0] RST_LOW_THR    = 14'd3500;
  localparam logic [MV_W-1:0] RST_ABSENT     = 14'd500;
  localparam logic [MV_W-1:0] RST_EMPTY      = 14'd3500;
  localparam logic [MV_W-1:0] RST_FULL       = 14'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_SCALE = 3'd0,
    CFG_LOW_THR    = 3'd1,
    CFG_ABSENT     = 3'd2,
    CFG_EMPTY      = 3'd3,
    CFG_FULL       = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE_EST,
    ST_SCALE_REM,
    ST_SCALE_FIX,
    ST_UPDATE,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_PCT,
    ST_PCT_GO,
    ST_PCT_WAIT,
    ST_FIN
  } state_e;

  typedef enum logic {
    DSEL_MEAN,
    DSEL_PCT
  } div_sel_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic     take_in;
    logic     mul_ld;
    logic     ring_rd;
    logic     est_ld;
    logic     rem_ld;
    logic     div_start;
    div_sel_e div_sel;
    logic     mv_ld;
    logic     ring_upd;
    logic     mean_ld;
    logic     pct_eval;
    logic     pct_ld;
    logic     out_ld;
  } ctl_t;

endpackage
`default_nettype wire

### hw/rtl/bva_divider.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module bva_divider import bva_pkg::*; #(
  parameter int N = 26,
  parameter int D = 17
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [N-1:0] dividend_i,
  input  wire logic [D-1:0] divisor_i,
  output logic      [N-1:0] quotient_o,
  output div_stat_t         stat_o
);

  localparam int CNT_W = $clog2(N + 1);

  logic [N-1:0]     quo_q;
  logic [D-1:0]     rem_q;
  logic [D-1:0]     dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [D:0]   rem_sh;
  logic [D+1:0] diff;
  logic         fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[N-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    fits   = ~diff[D+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(N);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[N-2:0], fits};
      rem_q <= fits ? diff[D-1:0] : rem_sh[D-1:0];
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

### hw/rtl/battery_voltage_averager_core.sv
// The serial divider runs the mean and percentage divisions in turn; the percentage
//   division is skipped when the percentage clamps to 0 or 100.
// A new sample is taken only after the previous result is registered; a stalled result
//   holds the next one in the final state.
// Reset: control and configuration registers return to their defaults, the ring reads as empty through
//   the fill flag, so no clearing pass is needed.
`default_nettype none
module battery_voltage_averager_core import bva_pkg::*; #(
  parameter int RING_DEPTH     = 16,
  parameter int ADC_FULL_COUNT = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [MV_W-1:0]      cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [ADC_W-1:0]     adc_sample_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [MV_W-1:0]      sample_mv_o,
  output logic      [MV_W-1:0]      mean_mv_o,
  output logic      [PCT_W-1:0]     charge_percent_o,
  output logic                      battery_low_o
);

  localparam int SLOT_W  = $clog2(RING_DEPTH);
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int TOTAL_W = MV_W + SLOT_W;
  localparam int DIV_N   = (TOTAL_W > PCT_NUM_W) ? TOTAL_W : PCT_NUM_W;
  localparam int DIV_D   = (CNT_W > MV_W) ? CNT_W : MV_W;

  // reciprocal of the full count; the estimate is at most one below the true quotient
  localparam int RECIP = (1 << PROD_W) / ADC_FULL_COUNT;
  localparam int RCP_W = $clog2(RECIP + 1);
  localparam int EST_W = PROD_W + RCP_W;
  localparam logic [RCP_W-1:0]  RCP_K   = RCP_W'(RECIP);
  localparam logic [PROD_W-1:0] ADC_DIV = PROD_W'(ADC_FULL_COUNT);

  // configuration
  logic [MV_W-1:0] full_scale_q, low_thr_q, absent_q, empty_q, full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= RST_FULL_SCALE;
      low_thr_q    <= RST_LOW_THR;
      absent_q     <= RST_ABSENT;
      empty_q      <= RST_EMPTY;
      full_q       <= RST_FULL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FULL_SCALE: full_scale_q <= cfg_data_i;
        CFG_LOW_THR:    low_thr_q    <= cfg_data_i;
        CFG_ABSENT:     absent_q     <= cfg_data_i;
        CFG_EMPTY:      empty_q      <= cfg_data_i;
        CFG_FULL:       full_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  state_e state_q, state_d;
  ctl_t   ctl;

  logic                 out_valid_q;
  logic [ADC_W-1:0]     raw_q;
  logic [PROD_W-1:0]    prod_q;
  logic [PROD_W-1:0]    est_q;
  logic [PROD_W-1:0]    srem_q;
  logic [MV_W-1:0]      old_q;
  logic [MV_W-1:0]      mv_q;
  logic [MV_W-1:0]      mean_q;
  logic [PCT_W-1:0]     pct_q;
  logic [PCT_NUM_W-1:0] pct_num_q;
  logic [SLOT_W-1:0]    slot_q;
  logic                 filled_q;
  logic [TOTAL_W-1:0]   total_q;

  div_stat_t         div_stat;
  logic [DIV_N-1:0]  div_quo;
  logic [DIV_N-1:0]  div_dividend;
  logic [DIV_D-1:0]  div_divisor;
  logic [MV_W-1:0]   quo_sat;
  logic [CNT_W-1:0]  count;
  logic              pct_hi, pct_lo;
  logic [EST_W-1:0]  est_full;
  logic [PROD_W-1:0] scale_quo;
  logic [MV_W-1:0]   scale_sat;

  assign pct_hi = (mean_q >= full_q);
  assign pct_lo = (mean_q <= empty_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (in_valid_i) state_d = ST_MUL;
      ST_MUL:        state_d = ST_SCALE_EST;
      ST_SCALE_EST:  state_d = ST_SCALE_REM;
      ST_SCALE_REM:  state_d = ST_SCALE_FIX;
      ST_SCALE_FIX:  state_d = ST_UPDATE;
      ST_UPDATE:     state_d = ST_MEAN_GO;
      ST_MEAN_GO:    state_d = ST_MEAN_WAIT;
      ST_MEAN_WAIT:  if (div_stat.done) state_d = ST_PCT;
      ST_PCT:        state_d = (pct_hi || pct_lo) ? ST_FIN : ST_PCT_GO;
      ST_PCT_GO:     state_d = ST_PCT_WAIT;
      ST_PCT_WAIT:   if (div_stat.done) state_d = ST_FIN;
      ST_FIN:        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl         = '0;
    ctl.div_sel = DSEL_MEAN;
    unique case (state_q)
      ST_IDLE:       ctl.take_in = in_valid_i;
      ST_MUL: begin
        ctl.mul_ld  = 1'b1;
        ctl.ring_rd = 1'b1;
      end
      ST_SCALE_EST:  ctl.est_ld = 1'b1;
      ST_SCALE_REM:  ctl.rem_ld = 1'b1;
      ST_SCALE_FIX:  ctl.mv_ld = 1'b1;
      ST_UPDATE:     ctl.ring_upd = 1'b1;
      ST_MEAN_GO: begin
        ctl.div_start = 1'b1;
        ctl.div_sel   = DSEL_MEAN;
      end
      ST_MEAN_WAIT:  ctl.mean_ld = div_stat.done;
      ST_PCT:        ctl.pct_eval = 1'b1;
      ST_PCT_GO: begin
        ctl.div_start = 1'b1;
        ctl.div_sel   = DSEL_PCT;
      end
      ST_PCT_WAIT:   ctl.pct_ld = div_stat.done;
      ST_FIN:        ctl.out_ld = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // scaling by the full count: reciprocal estimate, then one remainder correction
  assign est_full  = EST_W'(prod_q) * EST_W'(RCP_K);
  assign scale_quo = est_q + ((srem_q >= ADC_DIV) ? PROD_W'(1) : PROD_W'(0));
  assign scale_sat = (|scale_quo[PROD_W-1:MV_W]) ? MV_MAX : scale_quo[MV_W-1:0];

  // divider operands
  always_comb begin
    count = filled_q ? CNT_W'(RING_DEPTH) : CNT_W'(slot_q);
    if (count == '0) count = CNT_W'(1);
  end

  always_comb begin
    unique case (ctl.div_sel)
      DSEL_MEAN: begin
        div_dividend = DIV_N'(total_q);
        div_divisor  = DIV_D'(count);
      end
      DSEL_PCT: begin
        div_dividend = DIV_N'(pct_num_q);
        div_divisor  = DIV_D'(full_q - empty_q);
      end
    endcase
  end

  assign quo_sat = (|div_quo[DIV_N-1:MV_W]) ? MV_MAX : div_quo[MV_W-1:0];

  bva_divider #(
    .N(DIV_N),
    .D(DIV_D)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ctl.div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .quotient_o(div_quo),
    .stat_o    (div_stat)
  );

  // sample ring; entries past the fill point are not subtracted from the total until the first wrap
  logic [MV_W-1:0] ring_mem [RING_DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl.ring_upd) ring_mem[slot_q] <= mv_q;
    if (ctl.ring_rd)  old_q <= ring_mem[slot_q];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      filled_q    <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctl.ring_upd) begin
        total_q <= total_q - (filled_q ? TOTAL_W'(old_q) : '0) + TOTAL_W'(mv_q);
        if (slot_q == SLOT_W'(RING_DEPTH - 1)) begin
          slot_q   <= '0;
          filled_q <= 1'b1;
        end else begin
          slot_q <= slot_q + SLOT_W'(1);
        end
      end
      if (ctl.out_ld) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (ctl.take_in) raw_q  <= adc_sample_i;
    if (ctl.mul_ld)  prod_q <= PROD_W'(raw_q) * PROD_W'(full_scale_q);
    if (ctl.est_ld)  est_q  <= PROD_W'(est_full[EST_W-1:PROD_W]);
    if (ctl.rem_ld)  srem_q <= prod_q - est_q * ADC_DIV;
    if (ctl.mv_ld)   mv_q   <= scale_sat;
    if (ctl.mean_ld) mean_q <= quo_sat;
    if (ctl.pct_eval) begin
      if (pct_hi) pct_q <= PCT_FULL;
      else if (pct_lo) pct_q <= PCT_ZERO;
      pct_num_q <= PCT_NUM_W'(mean_q - empty_q) * PCT_NUM_W'(PCT_MUL);
    end
    if (ctl.pct_ld) pct_q <= div_quo[PCT_W-1:0];
    if (ctl.out_ld) begin
      sample_mv_o      <= mv_q;
      mean_mv_o        <= mean_q;
      charge_percent_o <= pct_q;
      battery_low_o    <= (mean_q > absent_q) && (mean_q < low_thr_q);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

### hw/rtl/bva_checker.sv
// Port-level checker for the averager core, bound into the core module.
`default_nettype none
`include "battery_voltage_averager_core_macros.svh"
module bva_checker import bva_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [MV_W-1:0]  sample_mv_o,
  input wire logic [MV_W-1:0]  mean_mv_o,
  input wire logic [PCT_W-1:0] charge_percent_o,
  input wire logic             battery_low_o
);

  property p_out_hold;
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_mv_o) && $stable(mean_mv_o)
      && $stable(charge_percent_o) && $stable(battery_low_o);
  endproperty

  `BVA_ASSERT(a_busy_after_take, in_valid_i && in_ready_o |=> !in_ready_o, "ready after accept")
  `BVA_ASSERT(a_pct_range, out_valid_o |-> charge_percent_o <= PCT_FULL, "percent above 100")
  `BVA_ASSERT(a_out_hold, p_out_hold, "stalled result changed")
  `BVA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "result valid in reset")

endmodule

bind battery_voltage_averager_core bva_checker u_bva_checker (.*);
`default_nettype wire
